[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFIP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GFIP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/gfip_pkg.sv]
`default_nettype none
package gfip_pkg;

   localparam int NODE_IDX_W  = 6;
   localparam int NODE_ADDR_W = 2 * NODE_IDX_W;
   localparam int FIELD_W     = 18;
   localparam int PARTS       = 6;
   localparam int ENTRY_W     = PARTS * FIELD_W;

   typedef logic [NODE_ADDR_W-1:0] node_addr_type;
   typedef logic [ENTRY_W-1:0]     node_entry_type;
   typedef logic signed [FIELD_W-1:0] trig_type;

endpackage
`default_nettype wire

[rtl/grid_field_interp_phase.sv]
// Grid field lookup with phase rotation.
// req_ channel: tuser is the opcode (0 evaluate a point, 1 load one grid node);
// tdata carries the point and the node fields. A load writes one node of the
// table and returns nothing; an evaluate returns one rsp_ transaction with six
// interpolated, phase rotated field parts and the on-grid flag in tuser.
// csr_ channel: register index and 32-bit data, always ready; write only while
// no evaluate is in flight.
// Throughput: one transaction per cycle, evaluates and loads alike, with no gaps
// while the receiver takes every result. The depth of the pipeline is set by the
// chain of multiplies in the phase path: angle generation and the five-term odd
// sine polynomial of ninth degree, run as a deep pipeline.
// The node table is four copies of a 4096-entry memory, one per neighbour, so
// all four corners are read in the same cycle; its contents are undefined until
// loaded, and a load is seen by every evaluate accepted after it.
// Reset clears the pipeline valid bits and loads the register defaults.
// When the receiver stalls, the whole pipeline holds and req_tready falls, so
// nothing is lost or repeated.
`default_nettype none
module grid_field_interp_phase #(
   parameter int GRID_POINTS      = 64,
   parameter int PHASE_TABLE_SIZE = 1024
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // x_coord, y_coord, z_coord, node_row, node_col, load_ex_re, load_ey_re,
   // load_ez_re, load_ex_im, load_ey_im, load_ez_im
   input  wire  [215:0] req_tdata,
   // opcode
   input  wire  [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // out_ex_re, out_ey_re, out_ez_re, out_ex_im, out_ey_im, out_ez_im, 4 zero bits
   output logic [111:0] rsp_tdata,
   // on_grid
   output logic [0:0]   rsp_tuser,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [2:0]   csr_index,
   input  wire  [31:0]  csr_data
);

   typedef enum logic [2:0] {
      CSR_DUAL_MIRROR, CSR_GRID_TOP, CSR_INV_SPACING, CSR_HALF_WIDTH,
      CSR_HALF_HEIGHT, CSR_K_INSIDE, CSR_K_OUTSIDE, CSR_Z_ORIGIN
   } csr_index_type;

   typedef logic signed [18:0] val_type;
   typedef val_type val_set_type [6];

   localparam int FW = gfip_pkg::FIELD_W;
   localparam logic [32:0] GP      = 33'(GRID_POINTS);
   localparam logic [12:0] PH_SIZE = 13'(PHASE_TABLE_SIZE);
   localparam logic [26:0] PH_Q    = 27'(64'h1_0000_0000 / PHASE_TABLE_SIZE);
   localparam logic [12:0] PH_R    = 13'(64'h1_0000_0000 % PHASE_TABLE_SIZE);
   localparam logic [30:0] PH_INV  = 31'(64'h10_0000_0000 / PHASE_TABLE_SIZE);
   localparam logic [29:0] TURN_Q32 = 30'd683565276;
   localparam int LAST = 18;

   function automatic logic signed [FW-1:0] sat18(input logic signed [21:0] v);
      if (v > 22'sd131071) begin
         return 18'sh1FFFF;
      end else if (v < -22'sd131072) begin
         return 18'sh20000;
      end
      return v[FW-1:0];
   endfunction

   // Configuration.
   logic               cfg_dual_ff;
   logic [30:0]        cfg_top_ff;
   logic [31:0]        cfg_inv_ff;
   logic [30:0]        cfg_hw_ff;
   logic [30:0]        cfg_hh_ff;
   logic [31:0]        cfg_kin_ff;
   logic [31:0]        cfg_kout_ff;
   logic signed [31:0] cfg_zo_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_dual_ff <= 1'b0;
         cfg_top_ff  <= 31'd65536;
         cfg_inv_ff  <= 32'd65536;
         cfg_hw_ff   <= '0;
         cfg_hh_ff   <= '0;
         cfg_kin_ff  <= '0;
         cfg_kout_ff <= '0;
         cfg_zo_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DUAL_MIRROR: cfg_dual_ff <= csr_data[0];
            CSR_GRID_TOP:    cfg_top_ff  <= csr_data[30:0];
            CSR_INV_SPACING: cfg_inv_ff  <= csr_data;
            CSR_HALF_WIDTH:  cfg_hw_ff   <= csr_data[30:0];
            CSR_HALF_HEIGHT: cfg_hh_ff   <= csr_data[30:0];
            CSR_K_INSIDE:    cfg_kin_ff  <= csr_data;
            CSR_K_OUTSIDE:   cfg_kout_ff <= csr_data;
            CSR_Z_ORIGIN:    cfg_zo_ff   <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // Pipeline control: one global advance, valid bits per stage.
   logic        adv;
   logic [LAST:0] ev_ff;
   logic [3:0]  ld_ff;

   assign adv        = !ev_ff[LAST] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = ev_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff <= '0;
         ld_ff <= '0;
      end else if (adv) begin
         ev_ff <= {ev_ff[LAST-1:0], req_tvalid & ~req_tuser[0]};
         ld_ff <= {ld_ff[2:0], req_tvalid & req_tuser[0]};
      end
   end

   // Stage 1: input register.
   logic [215:0] in1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         in1_ff <= req_tdata;
      end
   end

   // Stage 2: magnitudes, grid offsets, wavenumber choice, phase distance.
   logic signed [31:0] x_in, y_in, z_in;
   logic signed [32:0] xe_in, ye_in, ze_in;
   logic [31:0]        ax_in, ay_in;
   logic signed [33:0] dxw_in, dyw_in, d_in;
   logic               offa_in;
   logic [31:0]        k_in;

   always_comb begin
      x_in   = $signed(in1_ff[31:0]);
      y_in   = $signed(in1_ff[63:32]);
      z_in   = $signed(in1_ff[95:64]);
      xe_in  = 33'(x_in);
      ye_in  = 33'(y_in);
      ze_in  = cfg_dual_ff ? -33'(z_in) : 33'(z_in);
      ax_in  = xe_in[32] ? 32'(-xe_in) : 32'(xe_in);
      ay_in  = ye_in[32] ? 32'(-ye_in) : 32'(ye_in);
      dxw_in = $signed({3'b0, cfg_top_ff}) - 34'(x_in);
      dyw_in = $signed({3'b0, cfg_top_ff}) - 34'(y_in);
      d_in   = 34'(ze_in) - 34'(cfg_zo_ff);
      offa_in = (ax_in >= {1'b0, cfg_top_ff}) || (ay_in >= {1'b0, cfg_top_ff});
      k_in   = (ax_in <= {1'b0, cfg_hw_ff} && ay_in <= {1'b0, cfg_hh_ff})
               ? cfg_kin_ff : cfg_kout_ff;
   end

   logic [31:0]        dx2_ff, dy2_ff, k2_ff;
   logic signed [33:0] d2_ff, d3_ff;
   logic               off2_ff, off3_ff;
   gfip_pkg::node_addr_type  la2_ff, la3_ff, la4_ff;
   gfip_pkg::node_entry_type ldat2_ff, ldat3_ff, ldat4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dx2_ff   <= dxw_in[31:0];
         dy2_ff   <= dyw_in[31:0];
         k2_ff    <= k_in;
         d2_ff    <= d_in;
         off2_ff  <= offa_in;
         la2_ff   <= {in1_ff[101:96], in1_ff[107:102]};
         ldat2_ff <= in1_ff[215:108];
      end
   end

   // Stage 3: grid position products and turn rate.
   logic [63:0] ux3_ff, uy3_ff;
   logic [61:0] rate3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ux3_ff   <= 64'(dx2_ff) * 64'(cfg_inv_ff);
         uy3_ff   <= 64'(dy2_ff) * 64'(cfg_inv_ff);
         rate3_ff <= 62'(k2_ff) * 62'(TURN_Q32);
         d3_ff    <= d2_ff;
         off3_ff  <= off2_ff;
         la3_ff   <= la2_ff;
         ldat3_ff <= ldat2_ff;
      end
   end

   // Stage 4: cell indices, fractions, corner addresses, phase partial products.
   logic [32:0]        ix_in, iy_in;
   logic [31:0]        nx_in, ny_in;
   logic [5:0]         rx1_in, rx0_in, cy1_in, cy0_in;
   logic               off4_in;
   logic signed [65:0] p1_in, p2_in;

   always_comb begin
      ix_in  = {1'b0, ux3_ff[63:32]} + 33'(ux3_ff[31:0] != '0);
      iy_in  = {1'b0, uy3_ff[63:32]} + 33'(uy3_ff[31:0] != '0);
      nx_in  = 32'd0 - ux3_ff[31:0];
      ny_in  = 32'd0 - uy3_ff[31:0];
      rx1_in = ix_in[5:0];
      rx0_in = ix_in[5:0] - 6'd1;
      cy1_in = iy_in[5:0];
      cy0_in = iy_in[5:0] - 6'd1;
      off4_in = off3_ff || ix_in == '0 || iy_in == '0 || ix_in >= GP || iy_in >= GP;
      p1_in  = d3_ff * $signed({1'b0, rate3_ff[30:0]});
      p2_in  = d3_ff * $signed({1'b0, rate3_ff[61:31]});
   end

   logic [15:0] fx4_ff, fy4_ff;
   logic        off4_ff;
   gfip_pkg::node_addr_type ra4_ff [4];
   logic [63:0] p1_4_ff;
   logic [32:0] p2_4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         fx4_ff   <= nx_in[31:16];
         fy4_ff   <= ny_in[31:16];
         off4_ff  <= off4_in;
         ra4_ff[0] <= {rx1_in, cy1_in};
         ra4_ff[1] <= {rx1_in, cy0_in};
         ra4_ff[2] <= {rx0_in, cy0_in};
         ra4_ff[3] <= {rx0_in, cy1_in};
         p1_4_ff  <= p1_in[63:0];
         p2_4_ff  <= p2_in[32:0];
         la4_ff   <= la3_ff;
         ldat4_ff <= ldat3_ff;
      end
   end

   // Stage 5: node table read (or load write), weights, turn fraction.
   gfip_pkg::node_entry_type rd5 [4];

   for (genvar n = 0; n < 4; n++) begin : g_ram
      gfip_node_ram u_ram (
         .clock (clock),
         .we    (adv & ld_ff[3]),
         .waddr (la4_ff),
         .wdata (ldat4_ff),
         .re    (adv),
         .raddr (ra4_ff[n]),
         .rdata (rd5[n])
      );
   end

   logic [16:0] gx_in, gy_in;
   logic [63:0] pm_in, fr_in;
   logic [33:0] w_in [4];

   always_comb begin
      gx_in  = 17'd65536 - 17'(fx4_ff);
      gy_in  = 17'd65536 - 17'(fy4_ff);
      w_in[0] = 34'(gx_in) * 34'(gy_in);
      w_in[1] = 34'(gx_in) * 34'(fy4_ff);
      w_in[2] = 34'(fx4_ff) * 34'(fy4_ff);
      w_in[3] = 34'(fx4_ff) * 34'(gy_in);
      pm_in  = p1_4_ff + {p2_4_ff, 31'b0};
      fr_in  = 64'd0 - pm_in;
   end

   logic [32:0] w5_ff [4];
   logic [31:0] fhi5_ff;
   logic        off5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < 4; n++) begin
            w5_ff[n] <= w_in[n][32:0];
         end
         fhi5_ff <= fr_in[63:32];
         off5_ff <= off4_ff;
      end
   end

   // Stage 6: weighted node products, phase table step.
   logic [44:0] jt_in;
   logic [12:0] j_in;
   logic signed [51:0] prod6_ff [6][4];
   logic [12:0] j6_ff;
   logic        off6_ff;

   always_comb begin
      jt_in = 45'(fhi5_ff) * 45'(PH_SIZE) + 45'h8000_0000;
      j_in  = (jt_in[44:32] == PH_SIZE) ? 13'd0 : jt_in[44:32];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < 6; p++) begin
            for (int n = 0; n < 4; n++) begin
               prod6_ff[p][n] <= $signed({1'b0, w5_ff[n]}) * $signed(rd5[n][FW*p +: FW]);
            end
         end
         j6_ff   <= j_in;
         off6_ff <= off5_ff;
      end
   end

   // Stage 7: bilinear sums rounded to Q1.16; angle split into quotient parts.
   logic signed [53:0] acc_in [6];
   val_set_type v7_ff;
   logic [24:0] t7_ff;
   logic [39:0] base7_ff;
   logic        off7_ff;

   always_comb begin
      for (int p = 0; p < 6; p++) begin
         acc_in[p] = 54'(prod6_ff[p][0]) + 54'(prod6_ff[p][1]) + 54'(prod6_ff[p][2])
                   + 54'(prod6_ff[p][3]) + 54'sh8000_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < 6; p++) begin
            v7_ff[p] <= acc_in[p][50:32];
         end
         t7_ff    <= 25'(j6_ff) * 25'(PH_R);
         base7_ff <= 40'(j6_ff) * 40'(PH_Q);
         off7_ff  <= off6_ff;
      end
   end

   // Stage 8: reciprocal estimate of the remainder quotient.
   logic [55:0] qp_in;
   logic [12:0] qe8_ff;
   logic [24:0] t8_ff;
   logic [31:0] base8_ff;

   assign qp_in = 56'(t7_ff) * 56'(PH_INV);

   always_ff @(posedge clock) begin
      if (adv) begin
         qe8_ff   <= qp_in[48:36];
         t8_ff    <= t7_ff;
         base8_ff <= base7_ff[31:0];
      end
   end

   // Stage 9: correct the estimate by at most one and form the angle.
   logic [25:0] qm_in;
   logic [12:0] q_in;
   logic [31:0] ang9_ff;

   always_comb begin
      qm_in = 26'(qe8_ff) * 26'(PH_SIZE);
      q_in  = (26'(t8_ff) >= qm_in + 26'(PH_SIZE)) ? qe8_ff + 13'd1 : qe8_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang9_ff <= base8_ff + 32'(q_in);
      end
   end

   // Stages 10 to 17: sine and cosine.
   gfip_pkg::trig_type s17, c17;

   gfip_qsin u_sin (
      .clock (clock),
      .adv   (adv),
      .ang   (ang9_ff),
      .sin_q (s17)
   );

   gfip_qsin u_cos (
      .clock (clock),
      .adv   (adv),
      .ang   (ang9_ff + 32'h4000_0000),
      .sin_q (c17)
   );

   // Field values wait for the phase path.
   val_set_type vd_ff [10];
   logic [9:0]  offd_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         vd_ff[0]   <= v7_ff;
         offd_ff[0] <= off7_ff;
         for (int i = 1; i < 10; i++) begin
            vd_ff[i]   <= vd_ff[i-1];
            offd_ff[i] <= offd_ff[i-1];
         end
      end
   end

   // Stage 18: rotation products.
   logic signed [36:0] rc18_ff [3], is18_ff [3], rs18_ff [3], ic18_ff [3];
   logic               off18_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < 3; p++) begin
            rc18_ff[p] <= vd_ff[9][p] * c17;
            is18_ff[p] <= vd_ff[9][p+3] * s17;
            rs18_ff[p] <= vd_ff[9][p] * s17;
            ic18_ff[p] <= vd_ff[9][p+3] * c17;
         end
         off18_ff <= offd_ff[9];
      end
   end

   // Stage 19: round, saturate, zero off-grid results, output register.
   logic signed [37:0] nr_in [3], ni_in [3];
   logic [107:0]       res_in;
   logic [107:0]       res_ff;
   logic               on_ff;

   always_comb begin
      res_in = '0;
      for (int p = 0; p < 3; p++) begin
         nr_in[p] = 38'(rc18_ff[p]) - 38'(is18_ff[p]) + 38'sd32768;
         ni_in[p] = 38'(rs18_ff[p]) + 38'(ic18_ff[p]) + 38'sd32768;
         res_in[FW*p +: FW]     = sat18(nr_in[p][37:16]);
         res_in[FW*(p+3) +: FW] = sat18(ni_in[p][37:16]);
      end
      if (off18_ff) begin
         res_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         on_ff  <= !off18_ff;
      end
   end

   assign rsp_tdata = {4'b0, res_ff};
   assign rsp_tuser = on_ff;

endmodule
`default_nettype wire

[rtl/gfip_node_ram.sv]
`default_nettype none
module gfip_node_ram (
   input  wire                        clock,
   input  wire                        we,
   input  wire gfip_pkg::node_addr_type  waddr,
   input  wire gfip_pkg::node_entry_type wdata,
   input  wire                        re,
   input  wire gfip_pkg::node_addr_type  raddr,
   output gfip_pkg::node_entry_type   rdata
);

   localparam int DEPTH = 2 ** gfip_pkg::NODE_ADDR_W;

   gfip_pkg::node_entry_type mem [DEPTH];
   gfip_pkg::node_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem[raddr];
      end
   end

   assign rdata = rd_ff;

endmodule
`default_nettype wire

[rtl/gfip_qsin.sv]
`default_nettype none
module gfip_qsin (
   input  wire               clock,
   input  wire               adv,
   input  wire        [31:0] ang,
   output gfip_pkg::trig_type sin_q
);

   localparam logic signed [31:0] C1 = 32'sd1686629713;
   localparam logic signed [31:0] C3 = -32'sd693598668;
   localparam logic signed [31:0] C5 = 32'sd85569306;
   localparam logic signed [31:0] C7 = -32'sd5026995;
   localparam logic signed [31:0] C9 = 32'sd172272;

   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] r,
                                                  input logic [30:0] t);
      logic signed [63:0] pr;
      pr = r * $signed({1'b0, t});
      return $signed(pr[61:30]);
   endfunction

   logic [30:0]        t_ff   [0:5];
   logic [30:0]        t2_ff  [1:4];
   logic               neg_ff [0:6];
   logic signed [31:0] r_ff   [2:5];
   logic signed [31:0] m_ff;
   gfip_pkg::trig_type sin_ff;

   logic [30:0]        t_in;
   logic [61:0]        sq_in;
   logic signed [31:0] q_in;
   logic [16:0]        qc_in;
   gfip_pkg::trig_type sin_in;

   always_comb begin
      // Mirror the second and fourth quadrants onto the first.
      t_in  = ang[30] ? (31'h4000_0000 - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};
      sq_in = 62'(t_ff[0]) * 62'(t_ff[0]);
      q_in  = (m_ff + 32'sd8192) >>> 14;
      if (q_in < 0) begin
         qc_in = '0;
      end else if (q_in > 32'sd65536) begin
         qc_in = 17'd65536;
      end else begin
         qc_in = q_in[16:0];
      end
      sin_in = neg_ff[6] ? -$signed({1'b0, qc_in}) : $signed({1'b0, qc_in});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff[0]   <= t_in;
         neg_ff[0] <= ang[31];
         for (int i = 1; i < 6; i++) begin
            t_ff[i] <= t_ff[i-1];
         end
         for (int i = 1; i < 7; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
         t2_ff[1] <= sq_in[60:30];
         for (int i = 2; i < 5; i++) begin
            t2_ff[i] <= t2_ff[i-1];
         end
         r_ff[2] <= C7 + mul_q30(C9, t2_ff[1]);
         r_ff[3] <= C5 + mul_q30(r_ff[2], t2_ff[2]);
         r_ff[4] <= C3 + mul_q30(r_ff[3], t2_ff[3]);
         r_ff[5] <= C1 + mul_q30(r_ff[4], t2_ff[4]);
         m_ff    <= mul_q30(r_ff[5], t_ff[5]);
         sin_ff  <= sin_in;
      end
   end

   assign sin_q = sin_ff;

endmodule
`default_nettype wire

[rtl/gfip_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module gfip_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [111:0] rsp_tdata,
   input wire [0:0]   rsp_tuser,
   input wire         csr_valid,
   input wire         csr_ready
);

   // A result held back by the receiver keeps its payload.
   `GFIP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // An off-grid result carries all-zero field parts.
   `GFIP_ASSERT_NOW(a_off_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0)

   // A stalled output blocks new input transactions.
   `GFIP_ASSERT_NOW(a_stall_in, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

   // Configuration writes are never refused.
   `GFIP_ASSERT_NOW(a_csr_rdy, clock, reset, csr_valid, csr_ready)

   // No result is shown straight after reset.
   `GFIP_ASSERT_NEXT(a_rst_idle, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind grid_field_interp_phase gfip_checker u_gfip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
`default_nettype wire

[tb/tb_grid_field_interp_phase.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_grid_field_interp_phase;

   localparam int  GRID_N      = 64;
   localparam int  STEPS       = 1024;
   localparam int  DRAIN       = 40;
   localparam int  LONG_HOLD   = 300;
   localparam int  CYCLE_LIMIT = 400000;
   localparam longint TURN_SCALE = 64'd683565276;

   typedef enum logic [0:0] {OP_EVAL = 1'b0, OP_LOAD = 1'b1} opcode_e;
   typedef enum logic [2:0] {
      REG_DUAL_MIRROR, REG_GRID_TOP, REG_INV_SPACING, REG_HALF_WIDTH,
      REG_HALF_HEIGHT, REG_K_INSIDE, REG_K_OUTSIDE, REG_Z_ORIGIN
   } csr_reg_e;

   typedef struct {
      bit          mirror;
      logic [30:0] top;
      logic [31:0] inv;
      logic [30:0] hw;
      logic [30:0] hh;
      logic [31:0] k_in;
      logic [31:0] k_out;
      logic [31:0] z0;
   } grid_cfg_t;

   typedef struct {
      logic [17:0] part [6];
      bit          on_grid;
   } field_sample_t;

   typedef struct {
      opcode_e            op;
      logic signed [31:0] x, y, z;
      logic [5:0]         row, col;
      logic signed [17:0] fv;
      bit                 off_grid;   // expected result typed in: zeros, flag clear
   } vector_row_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   wire           req_tready;
   logic [215:0]  req_tdata = '0;
   logic [0:0]    req_tuser = '0;
   wire           rsp_tvalid;
   logic          rsp_tready = 1'b0;
   wire  [111:0]  rsp_tdata;
   wire  [0:0]    rsp_tuser;
   logic          csr_valid = 1'b0;
   wire           csr_ready;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_data = '0;

   grid_field_interp_phase i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   grid_cfg_t          cfg;
   logic signed [17:0] node_field [6][4096];
   field_sample_t      pending_fields [$];
   int                 mismatches = 0;
   int                 cycles = 0;
   bit                 steady_sink = 1'b0;
   bit                 hold_request = 1'b0;
   string              part_names [6] = '{"ex_re", "ey_re", "ez_re", "ex_im", "ey_im", "ez_im"};

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // sin(pi/2 * t) with t in Q30, result in Q16.
   function automatic longint quarter_sine(longint t);
      longint t2, r, q;
      t2 = (t * t) >>> 30;
      r  = 172272;
      r  = -5026995 + ((r * t2) >>> 30);
      r  = 85569306 + ((r * t2) >>> 30);
      r  = -693598668 + ((r * t2) >>> 30);
      r  = 1686629713 + ((r * t2) >>> 30);
      q  = (((r * t) >>> 30) + 8192) >>> 14;
      if (q < 0) q = 0;
      if (q > 65536) q = 65536;
      return q;
   endfunction

   function automatic longint turn_sine(logic [31:0] a);
      longint f;
      f = longint'(a[29:0]);
      case (a[31:30])
         2'd0: return quarter_sine(f);
         2'd1: return quarter_sine((64'd1 << 30) - f);
         2'd2: return -quarter_sine(f);
         default: return -quarter_sine((64'd1 << 30) - f);
      endcase
   endfunction

   function automatic longint cell_of(longint p, output longint frac);
      logic [63:0] u, i;
      u = 64'(longint'(cfg.top) - p) * 64'(cfg.inv);
      i = 64'(u[63:32]) + (u[31:0] != 0);
      if (i > GRID_N) i = GRID_N;
      frac = 0;
      if (i >= 1 && i < GRID_N) frac = longint'(((i << 32) - u) >> 16);
      return longint'(i);
   endfunction

   function automatic longint clip18(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   function automatic field_sample_t interp_rotate(logic signed [31:0] xs,
                                                   logic signed [31:0] ys,
                                                   logic signed [31:0] zs);
      field_sample_t r;
      longint x, y, z, ix, iy, fx, fy, acc, s, c, re, im;
      longint w [4];
      longint v [6];
      logic [11:0] a [4];
      logic [63:0] k, rate, phase_frac, j;
      logic [31:0] ang;
      x = xs; y = ys; z = zs;
      foreach (r.part[p]) r.part[p] = '0;
      r.on_grid = 1'b0;
      if (cfg.mirror) z = -z;
      if ((x < 0 ? -x : x) >= longint'(cfg.top) || (y < 0 ? -y : y) >= longint'(cfg.top))
         return r;
      ix = cell_of(x, fx);
      iy = cell_of(y, fy);
      if (ix == 0 || iy == 0 || ix >= GRID_N || iy >= GRID_N) return r;
      w[0] = (65536 - fx) * (65536 - fy);
      w[1] = (65536 - fx) * fy;
      w[2] = fx * fy;
      w[3] = fx * (65536 - fy);
      a[0] = {6'(ix), 6'(iy)};
      a[1] = {6'(ix), 6'(iy - 1)};
      a[2] = {6'(ix - 1), 6'(iy - 1)};
      a[3] = {6'(ix - 1), 6'(iy)};
      for (int p = 0; p < 6; p++) begin
         acc = 0;
         for (int n = 0; n < 4; n++) acc += w[n] * longint'(node_field[p][a[n]]);
         v[p] = (acc + (64'sd1 <<< 31)) >>> 32;
      end
      // The core box picks the wavenumber; the phase is then quantised to the table.
      k = ((x < 0 ? -x : x) <= longint'(cfg.hw) && (y < 0 ? -y : y) <= longint'(cfg.hh))
          ? 64'(cfg.k_in) : 64'(cfg.k_out);
      rate = k * TURN_SCALE;
      phase_frac = 64'd0 - (64'(z - longint'(signed'(cfg.z0))) * rate);
      j = (((phase_frac >> 32) * STEPS) + (64'd1 << 31)) >> 32;
      j = j % STEPS;
      ang = 32'((j << 32) / STEPS);
      s = turn_sine(ang);
      c = turn_sine(ang + 32'h4000_0000);
      for (int p = 0; p < 3; p++) begin
         re = v[p];
         im = v[p + 3];
         r.part[p]     = 18'(clip18((re * c - im * s + 32768) >>> 16));
         r.part[p + 3] = 18'(clip18((re * s + im * c + 32768) >>> 16));
      end
      r.on_grid = 1'b1;
      return r;
   endfunction

   function automatic logic [215:0] pack_req(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                             logic [5:0] row, logic [5:0] col,
                                             logic [17:0] f [6]);
      return {f[5], f[4], f[3], f[2], f[1], f[0], col, row, z, y, x};
   endfunction

   // Applies one accepted transaction to the node table or the expectation queue.
   task automatic account_item(opcode_e op, logic [215:0] d, bit off_typed);
      field_sample_t e;
      if (op == OP_LOAD) begin
         for (int p = 0; p < 6; p++) node_field[p][{d[101:96], d[107:102]}] = d[108 + 18*p +: 18];
      end else if (off_typed) begin
         foreach (e.part[p]) e.part[p] = '0;
         e.on_grid = 1'b0;
         pending_fields.push_back(e);
      end else begin
         pending_fields.push_back(interp_rotate(d[31:0], d[63:32], d[95:64]));
      end
   endtask

   task automatic send_item(opcode_e op, logic [215:0] d, int gap, bit off_typed);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      account_item(op, d, off_typed);
   endtask

   task automatic write_reg(csr_reg_e idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_config(grid_cfg_t c);
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      write_reg(REG_DUAL_MIRROR, 32'(c.mirror));
      write_reg(REG_GRID_TOP,    32'(c.top));
      write_reg(REG_INV_SPACING, c.inv);
      write_reg(REG_HALF_WIDTH,  32'(c.hw));
      write_reg(REG_HALF_HEIGHT, 32'(c.hh));
      write_reg(REG_K_INSIDE,    c.k_in);
      write_reg(REG_K_OUTSIDE,   c.k_out);
      write_reg(REG_Z_ORIGIN,    c.z0);
      csr_valid <= 1'b0;
      cfg = c;
   endtask

   function automatic logic [17:0] rand_field();
      return 18'($urandom);
   endfunction

   // Coordinate that mostly lands inside the grid for the present setting.
   function automatic logic [31:0] grid_coord();
      logic [63:0] span;
      if ($urandom_range(0, 4) == 0 || cfg.inv == 0 || cfg.top == 0) return $urandom;
      span = (64'd64 << 32) / 64'(cfg.inv);
      if (span > 2 * 64'(cfg.top)) span = 2 * 64'(cfg.top);
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      return 32'(longint'(cfg.top) - longint'($urandom_range(0, 32'(span))));
   endfunction

   task automatic random_phase(int count, bit pressure);
      logic [17:0] f [6];
      int gap;
      if (pressure) hold_request = 1'b1;
      steady_sink = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < count; n++) begin
         gap = (pressure || steady_sink) ? 0 : $urandom_range(0, 3);
         foreach (f[p]) f[p] = rand_field();
         if ($urandom_range(0, 99) < 15)
            send_item(OP_LOAD, pack_req($urandom, $urandom, $urandom, 6'($urandom),
                                        6'($urandom), f), gap, 1'b0);
         else
            send_item(OP_EVAL, pack_req(grid_coord(), grid_coord(), $urandom, 6'($urandom),
                                        6'($urandom), f), gap, 1'b0);
      end
   endtask

   function automatic grid_cfg_t random_config(bit mirror);
      grid_cfg_t c;
      int units;
      units   = $urandom_range(1, 2000);
      c.mirror = mirror;
      c.top   = 31'(units * 65536 + $urandom_range(0, 65535));
      c.inv   = 32'(((64'd63 << 31) / 64'(c.top)) * 65536 >> 16) + $urandom_range(0, 255);
      c.hw    = 31'($urandom_range(0, 32'(c.top)));
      c.hh    = 31'($urandom_range(0, 32'(c.top)));
      c.k_in  = $urandom;
      c.k_out = $urandom_range(0, 32'h0010_0000);
      c.z0    = $urandom;
      return c;
   endfunction

   // Receiver: random back-pressure, stretches of none, and one long hold-off.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = steady_sink ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      field_sample_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_fields.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with no evaluate outstanding: %h", rsp_tdata);
         end else begin
            e = pending_fields.pop_front();
            for (int p = 0; p < 6; p++)
               if (rsp_tdata[18*p +: 18] !== e.part[p]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%s: expected %h, got %h", part_names[p], e.part[p],
                              rsp_tdata[18*p +: 18]);
               end
            if (rsp_tuser[0] !== e.on_grid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("on_grid: expected %b, got %b", e.on_grid, rsp_tuser[0]);
            end
         end
      end
   end

   initial begin
      vector_row_t vectors [] = '{
         '{OP_LOAD, 0, 0, 0, 6'd0, 6'd0, 18'sd131071, 1'b0},
         '{OP_LOAD, 0, 0, 0, 6'd1, 6'd1, -18'sd131072, 1'b0},
         '{OP_LOAD, 0, 0, 0, 6'd0, 6'd1, 18'sd0, 1'b0},
         '{OP_LOAD, 0, 0, 0, 6'd1, 6'd2, 18'sd1, 1'b0},
         '{OP_LOAD, 0, 0, 0, 6'd63, 6'd63, -18'sd1, 1'b0},
         '{OP_EVAL, 32'sd0, 32'sd0, 32'sd0, 6'd0, 6'd0, 18'sd0, 1'b0},
         '{OP_EVAL, 32'sd65535, -32'sd65535, 32'sd0, 6'd0, 6'd0, 18'sd0, 1'b0},
         '{OP_EVAL, -32'sd65535, 32'sd65535, 32'h7FFF_FFFF, 6'd0, 6'd0, 18'sd0, 1'b0},
         '{OP_EVAL, 32'sd32768, 32'sd32768, 32'h8000_0000, 6'd0, 6'd0, 18'sd0, 1'b0},
         '{OP_EVAL, 32'sd1, -32'sd1, -32'sd1, 6'd0, 6'd0, 18'sd0, 1'b0},
         '{OP_EVAL, 32'sd65536, 32'sd0, 32'sd0, 6'd0, 6'd0, 18'sd0, 1'b1},
         '{OP_EVAL, 32'sd0, -32'sd65536, 32'sd0, 6'd0, 6'd0, 18'sd0, 1'b1},
         '{OP_EVAL, 32'h8000_0000, 32'sd0, 32'sd0, 6'd0, 6'd0, 18'sd0, 1'b1},
         '{OP_EVAL, 32'sd0, 32'h7FFF_FFFF, 32'sd0, 6'd0, 6'd0, 18'sd0, 1'b1},
         '{OP_EVAL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 6'd0, 6'd0, 18'sd0, 1'b1}
      };
      logic [17:0] f [6];
      grid_cfg_t c;

      cfg = '{1'b0, 31'd65536, 32'd65536, 31'd0, 31'd0, 32'd0, 32'd0, 32'd0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole node table so that no evaluate reads an unloaded node.
      for (int a = 0; a < 4096; a++) begin
         foreach (f[p]) f[p] = rand_field();
         send_item(OP_LOAD, pack_req($urandom, $urandom, $urandom, 6'(a >> 6), 6'(a), f),
                   0, 1'b0);
      end

      foreach (vectors[n]) begin
         foreach (f[p]) f[p] = vectors[n].fv;
         send_item(vectors[n].op, pack_req(vectors[n].x, vectors[n].y, vectors[n].z,
                                           vectors[n].row, vectors[n].col, f),
                   $urandom_range(0, 3), vectors[n].off_grid);
      end
      req_tvalid <= 1'b0;

      apply_config(random_config(1'b0));
      random_phase(200, 1'b0);
      req_tvalid <= 1'b0;
      apply_config(random_config(1'b1));
      random_phase(200, 1'b1);
      req_tvalid <= 1'b0;

      // Registers maxed, z origin at minimum: the grid lies within 63 LSBs below the top.
      c = '{1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000};
      apply_config(c);
      random_phase(200, 1'b0);
      req_tvalid <= 1'b0;

      // Every register at zero: nothing can fall inside the grid.
      apply_config('{1'b0, 31'd0, 32'd0, 31'd0, 31'd0, 32'd0, 32'd0, 32'h0});
      random_phase(100, 1'b0);
      req_tvalid <= 1'b0;

      // A normal grid top but zero inverse spacing puts every point off the grid.
      c = random_config(1'b0);
      c.inv = 32'd0;
      apply_config(c);
      random_phase(100, 1'b0);
      req_tvalid <= 1'b0;

      apply_config(random_config(1'b1));
      random_phase(300, 1'b0);
      req_tvalid <= 1'b0;
      apply_config(random_config(1'b0));
      random_phase(300, 1'b0);
      req_tvalid <= 1'b0;

      while (pending_fields.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
